// ----- rtl/core/spd_pkg.sv -----
package spd_pkg;

   // Default frame store depth in bytes
   localparam int SPD_BUFFER_DEPTH = 256;

   // Action codes
   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_HEADER   = 2'd1;
   localparam logic [1:0] ERR_LENGTH   = 2'd2;
   localparam logic [1:0] ERR_CHECKSUM = 2'd3;

   // Frame format
   localparam logic [7:0]  HDR_FIRST       = 8'hEF;
   localparam logic [7:0]  HDR_SECOND      = 8'h01;
   localparam logic [15:0] ADDR_BYTES      = 16'd4;
   localparam logic [7:0]  SPECIAL_ID      = 8'h07;
   localparam logic [7:0]  SPECIAL_LEN_LOW = 8'h19;
   localparam logic [15:0] SPECIAL_ADJUST  = 16'd6;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic        frame_done;
      logic [1:0]  error_kind;
      logic        receiving;
      logic [7:0]  packet_id;
      logic [15:0] payload_length;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

// ----- rtl/core/spd_intf.sv -----
interface spd_req_if import spd_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spd_rsp_if import spd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/spd_frame_store.sv -----
module spd_frame_store import spd_pkg::*; #(
   parameter int DEPTH = SPD_BUFFER_DEPTH,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data only moves on a read, so it holds through an output stall
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sensor_packet_deframer.sv -----
// Sensor packet deframer.
// req_chan carries one word per action: a received link byte, a release of
// the held frame, or a read of a buffered byte. rsp_chan returns exactly one
// word for every accepted request, in order.
// Frame: EF 01, four address bytes, id, length (hi, lo), length-2 data
// bytes, checksum (hi, lo). The whole frame is written to an on-chip byte
// buffer as it arrives; a running sum replaces any pass over the buffer.
// The response is registered and valid in the cycle after the request is accepted.
// Throughput: one word per cycle unless rsp_chan stalls; each word does at most
// one buffer write or read; the buffer's single write and read port set that figure.
// Read data comes straight from the buffer's registered read port, which
// doubles as the output register.
// Stall: while rsp_chan.ready is low the response holds and req_chan.ready
// drops; a new request is taken in the cycle the held one is taken.
// Reset (synchronous) returns to header hunt with no frame held; buffer
// contents are not cleared and no clearing pass is needed.
module sensor_packet_deframer import spd_pkg::*; #(
   parameter int BUFFER_DEPTH = SPD_BUFFER_DEPTH,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input logic       clock,
   input logic       reset,
   spd_req_if.sink   req_chan,
   spd_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR2,
      PH_ADDR,
      PH_ID,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_DATA,
      PH_CSUM_LO
   } phase_type;

   // frame state
   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  csum_hi_ff, csum_hi_in;
   logic        done_ff, done_in;

   // output stage
   logic        rsp_valid_ff;
   logic        rsp_done_ff;
   logic [1:0]  rsp_err_ff;
   logic        rsp_recv_ff;
   logic [7:0]  rsp_id_ff;
   logic [15:0] rsp_len_ff;
   logic        rsp_rd_sel_ff;
   logic [1:0]  err_in;
   logic        rd_sel_in;

   // buffer ports
   logic          wr_en;
   logic [15:0]   wr_pos;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [AW+7:0] idx_ext;

   logic          accept;
   req_type       req;
   logic [15:0]   count_dec;
   logic [15:0]   sum_chk;
   logic [16:0]   frame_end;

   assign req    = req_chan.data;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign count_dec = count_ff - 16'd1;
   // end of frame from the length being completed by this byte
   assign frame_end = {1'b0, len_ff[15:8], req.rx_byte} + 17'd9;
   assign idx_ext   = {{AW{1'b0}}, req.read_index};
   assign rd_addr   = idx_ext[AW-1:0];
   assign wr_addr   = wr_pos[AW-1:0];

   // checksum with the id 7 / length low 0x19 quirk
   always_comb begin
      sum_chk = sum_ff;
      if (id_ff == SPECIAL_ID && len_ff[7:0] == SPECIAL_LEN_LOW) begin
         sum_chk = sum_ff - SPECIAL_ADJUST;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      sum_in     = sum_ff;
      csum_hi_in = csum_hi_ff;
      done_in    = done_ff;
      err_in     = ERR_NONE;
      rd_sel_in  = 1'b0;
      wr_en      = 1'b0;
      wr_pos     = 16'd0;
      rd_en      = 1'b0;

      if (accept) begin
         unique case (req.action)
            ACT_BYTE: begin
               if (!done_ff) begin
                  unique case (phase_ff)
                     PH_IDLE: begin
                        if (req.rx_byte == HDR_FIRST) begin
                           wr_en    = 1'b1;
                           wr_pos   = 16'd0;
                           phase_in = PH_HDR2;
                        end
                     end
                     PH_HDR2: begin
                        if (req.rx_byte == HDR_SECOND) begin
                           wr_en    = 1'b1;
                           wr_pos   = 16'd1;
                           count_in = ADDR_BYTES;
                           phase_in = PH_ADDR;
                        end else begin
                           phase_in = PH_IDLE;
                           err_in   = ERR_HEADER;
                        end
                     end
                     PH_ADDR: begin
                        // positions 2..5 as the count runs 4..1
                        wr_en    = 1'b1;
                        wr_pos   = 16'd2 + (ADDR_BYTES - {13'd0, count_ff[2:0]});
                        count_in = count_dec;
                        if (count_dec == 16'd0 || count_dec > ADDR_BYTES) begin
                           count_in = 16'd0;
                           phase_in = PH_ID;
                        end
                     end
                     PH_ID: begin
                        wr_en    = 1'b1;
                        wr_pos   = 16'd6;
                        id_in    = req.rx_byte;
                        sum_in   = {8'd0, req.rx_byte};
                        phase_in = PH_LEN_HI;
                     end
                     PH_LEN_HI: begin
                        wr_en    = 1'b1;
                        wr_pos   = 16'd7;
                        len_in   = {req.rx_byte, 8'd0};
                        sum_in   = sum_ff + {8'd0, req.rx_byte};
                        phase_in = PH_LEN_LO;
                     end
                     PH_LEN_LO: begin
                        wr_en  = 1'b1;
                        wr_pos = 16'd8;
                        len_in = {len_ff[15:8], req.rx_byte};
                        sum_in = sum_ff + {8'd0, req.rx_byte};
                        if (len_in < 16'd2 || 32'(frame_end) > 32'(BUFFER_DEPTH)) begin
                           phase_in = PH_IDLE;
                           err_in   = ERR_LENGTH;
                        end else begin
                           count_in = len_in - 16'd1;
                           phase_in = PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        wr_en  = 1'b1;
                        wr_pos = 16'd9 + len_ff - 16'd1 - count_ff;
                        if (count_ff <= 16'd1) begin
                           // last one here is the checksum high byte
                           csum_hi_in = req.rx_byte;
                           count_in   = 16'd0;
                           phase_in   = PH_CSUM_LO;
                        end else begin
                           sum_in   = sum_ff + {8'd0, req.rx_byte};
                           count_in = count_dec;
                        end
                     end
                     PH_CSUM_LO: begin
                        wr_en  = 1'b1;
                        wr_pos = 16'd8 + len_ff;
                        if (sum_chk == {csum_hi_ff, req.rx_byte}) begin
                           done_in = 1'b1;
                        end else begin
                           err_in = ERR_CHECKSUM;
                        end
                        phase_in = PH_IDLE;
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
            ACT_RELEASE: begin
               done_in  = 1'b0;
               phase_in = PH_IDLE;
               count_in = 16'd0;
            end
            ACT_READ: begin
               if (32'(req.read_index) < 32'(BUFFER_DEPTH)) begin
                  rd_en     = 1'b1;
                  rd_sel_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= 16'd0;
         id_ff        <= 8'd0;
         len_ff       <= 16'd0;
         sum_ff       <= 16'd0;
         csum_hi_ff   <= 8'd0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         id_ff      <= id_in;
         len_ff     <= len_in;
         sum_ff     <= sum_in;
         csum_hi_ff <= csum_hi_in;
         done_ff    <= done_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_done_ff   <= done_in;
         rsp_err_ff    <= err_in;
         rsp_recv_ff   <= (phase_in != PH_IDLE);
         rsp_id_ff     <= id_in;
         rsp_len_ff    <= len_in;
         rsp_rd_sel_ff <= rd_sel_in;
      end
   end

   spd_frame_store #(
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.data.frame_done      = rsp_done_ff;
   assign rsp_chan.data.error_kind      = rsp_err_ff;
   assign rsp_chan.data.receiving       = rsp_recv_ff;
   assign rsp_chan.data.packet_id       = rsp_id_ff;
   assign rsp_chan.data.payload_length  = rsp_len_ff;
   assign rsp_chan.data.read_data       = rsp_rd_sel_ff ? rd_data : 8'd0;

endmodule
